// File: rtl/relativistic_particle_drift_macros.svh
// Assertion macros shared by the drift block.
`ifndef RELATIVISTIC_PARTICLE_DRIFT_MACROS_SVH
`define RELATIVISTIC_PARTICLE_DRIFT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define RPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define RPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/rpd_pkg.sv
// Package with types, constants and fixed-point helpers of the drift block.
package rpd_pkg;
   localparam int W = 48;
   localparam int FRAC = 40;
   localparam logic signed [W-1:0] MAXV = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [W-1:0] MINV = 48'sh8000_0000_0000;
   localparam int DIV_STAGES = 88;
   localparam int SQRT_STAGES = 45;
   localparam logic [2:0] REG_LEN = 3'd0;
   localparam logic [2:0] REG_BETA = 3'd1;
   localparam logic [2:0] REG_EK = 3'd2;
   localparam logic [2:0] REG_MASS = 3'd3;
   localparam logic [2:0] REG_P0 = 3'd4;

   typedef logic signed [W-1:0] q_type;

   typedef struct packed {
      q_type x, xp, y, yp, z, de;
   } particle_type;

   function automatic q_type sat49(input logic signed [W:0] v);
      if (v > 49'sh0_7FFF_FFFF_FFFF) return MAXV;
      if (v < -49'sh0_8000_0000_0000) return MINV;
      return v[W-1:0];
   endfunction

   function automatic q_type from_mag(input logic neg, input logic [63:0] m);
      if (neg) begin
         if (m >= 64'h8000_0000_0000) return MINV;
         return q_type'(-$signed(m[W-1:0]));
      end
      if (m > 64'h7FFF_FFFF_FFFF) return MAXV;
      return m[W-1:0];
   endfunction

   function automatic logic [W-1:0] mag(input q_type v);
      return v[W-1] ? W'(-v) : v;
   endfunction
endpackage

// File: rtl/rpd_qmul.sv
// Two-stage pipelined Q8.40 multiplier with truncation and saturation.
module rpd_qmul (
   input  logic clock,
   input  logic en,
   input  rpd_pkg::q_type a,
   input  rpd_pkg::q_type b,
   output rpd_pkg::q_type p
);
   logic [47:0] ma, mb;
   logic [47:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [95:0] pl_ff;
   logic neg_ff, neg2_ff;
   always_comb begin
      ma = rpd_pkg::mag(a);
      mb = rpd_pkg::mag(b);
   end
   // Stage one: four 24x24 partial products; stage two: combine.
   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= 48'(ma[23:0]) * 48'(mb[23:0]);
         pp_lh_ff <= 48'(ma[23:0]) * 48'(mb[47:24]);
         pp_hl_ff <= 48'(ma[47:24]) * 48'(mb[23:0]);
         pp_hh_ff <= 48'(ma[47:24]) * 48'(mb[47:24]);
         neg_ff <= a[47] ^ b[47];
         pl_ff <= {pp_hh_ff, pp_ll_ff} + (96'(pp_lh_ff) << 24) + (96'(pp_hl_ff) << 24);
         neg2_ff <= neg_ff;
      end
   end
   // The full product never exceeds 2^94, so saturation is left to from_mag.
   assign p = rpd_pkg::from_mag(neg2_ff, 64'(pl_ff[95:40]));
endmodule

// File: rtl/rpd_qdiv.sv
// Pipelined restoring divider, one quotient bit per stage, Q8.40 result.
module rpd_qdiv (
   input  logic clock,
   input  logic en,
   input  rpd_pkg::q_type a,
   input  rpd_pkg::q_type b,
   output rpd_pkg::q_type q
);
   localparam int N = rpd_pkg::DIV_STAGES;
   logic [87:0] num_ff [N+1];
   logic [48:0] rem_ff [N+1];
   logic [47:0] den_ff [N+1];
   logic [48:0] quo_ff [N+1];
   logic neg_ff [N+1], za_ff [N+1], zb_ff [N+1], sa_ff [N+1], ovf_ff [N+1];
   always_comb begin
      num_ff[0] = {rpd_pkg::mag(a), 40'd0};
      rem_ff[0] = '0;
      den_ff[0] = rpd_pkg::mag(b);
      quo_ff[0] = '0;
      neg_ff[0] = a[47] ^ b[47];
      za_ff[0] = (a == 0);
      zb_ff[0] = (b == 0);
      sa_ff[0] = a[47];
      ovf_ff[0] = 1'b0;
   end
   for (genvar k = 0; k < N; k++) begin : g_st
      logic [48:0] r;
      logic ge;
      always_comb begin
         r = {rem_ff[k][47:0], num_ff[k][87-k]};
         ge = r >= {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? r - {1'b0, den_ff[k]} : r;
            quo_ff[k+1] <= (quo_ff[k] << 1) | 49'(ge);
            num_ff[k+1] <= num_ff[k];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            za_ff[k+1] <= za_ff[k];
            zb_ff[k+1] <= zb_ff[k];
            sa_ff[k+1] <= sa_ff[k];
            ovf_ff[k+1] <= ovf_ff[k] | (ge & (k < N - 48));
         end
      end
   end
   // Any quotient bit at or above bit 48 means overflow; early ones are kept sticky.
   always_comb begin
      if (za_ff[N]) q = '0;
      else if (zb_ff[N]) q = sa_ff[N] ? rpd_pkg::MINV : rpd_pkg::MAXV;
      else if (ovf_ff[N] || quo_ff[N][48]) q = neg_ff[N] ? rpd_pkg::MINV : rpd_pkg::MAXV;
      else q = rpd_pkg::from_mag(neg_ff[N], 64'(quo_ff[N][47:0]));
   end
endmodule

// File: rtl/rpd_qsqrt.sv
// Pipelined bit-by-bit square root, floor of sqrt(v * 2^40).
module rpd_qsqrt (
   input  logic clock,
   input  logic en,
   input  logic [47:0] v,
   output rpd_pkg::q_type r
);
   localparam int N = rpd_pkg::SQRT_STAGES;
   logic [89:0] rad_ff [N+1];
   logic [89:0] rem_ff [N+1];
   logic [44:0] root_ff [N+1];
   always_comb begin
      rad_ff[0] = {2'b0, v, 40'd0};
      rem_ff[0] = '0;
      root_ff[0] = '0;
   end
   for (genvar k = 0; k < N; k++) begin : g_st
      logic [89:0] t, trial;
      always_comb begin
         t = {rem_ff[k][87:0], rad_ff[k][89-2*k -: 2]};
         trial = {43'd0, root_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= (t >= trial) ? t - trial : t;
            root_ff[k+1] <= {root_ff[k][43:0], t >= trial};
            rad_ff[k+1] <= rad_ff[k];
         end
      end
   end
   assign r = 48'(root_ff[N]);
endmodule

// File: rtl/relativistic_particle_drift.sv
// Top level: fully pipelined relativistic drift of one particle per cycle.
// One request is taken every cycle (busy is always low) and its result is on
// the rsp_ ports once it has passed the delay line and the output register;
// the delay line is matched to the square root and the divider for the
// longitudinal velocity in series, with the multipliers around them. The
// receiver cannot stall the output. Write registers only while idle.
`include "relativistic_particle_drift_macros.svh"
module relativistic_particle_drift (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  rpd_pkg::q_type req_in_x, req_in_xp, req_in_y, req_in_yp, req_in_z, req_in_de,
   output logic rsp_valid,
   output rpd_pkg::q_type rsp_out_x, rsp_out_xp, rsp_out_y, rsp_out_yp, rsp_out_z,
   output rpd_pkg::q_type rsp_out_de,
   input  logic csr_psel, csr_penable, csr_pwrite,
   input  logic [5:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   localparam int LM = 2;
   localparam int LD = rpd_pkg::DIV_STAGES;
   localparam int LS = rpd_pkg::SQRT_STAGES;
   // Stage timing of the chain.
   localparam int T_EK = 1;                 // ek, et registered
   localparam int T_P2 = T_EK + 1 + LM;     // p2 ready
   localparam int T_BXN = LM;               // xp*p0
   localparam int T_A2 = LM + 1;            // a2 registered
   localparam int T_PZ = T_A2 + LM + 1;     // pz2 registered (after p2 too)
   localparam int T_SQ = T_PZ + LS;
   localparam int T_BZ = T_SQ + LD;
   localparam int T_FIN = T_BZ + 1 + LM + 1;
   localparam int LAT = T_FIN;

   logic signed [47:0] len_ff;
   logic [40:0] beta_ff;
   logic [46:0] ek0_ff, mass_ff, p0_ff;
   logic wr;
   logic [2:0] idx;
   assign idx = csr_paddr[5:3];
   assign wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign busy = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; beta_ff <= 41'h100_0000_0000; ek0_ff <= '0;
         mass_ff <= 47'h100_0000_0000; p0_ff <= '0;
      end else if (wr) begin
         unique case (idx)
            rpd_pkg::REG_LEN:  len_ff <= csr_pwdata[47:0];
            rpd_pkg::REG_BETA: beta_ff <= csr_pwdata[40:0];
            rpd_pkg::REG_EK:   ek0_ff <= csr_pwdata[46:0];
            rpd_pkg::REG_MASS: mass_ff <= csr_pwdata[46:0];
            rpd_pkg::REG_P0:   p0_ff <= csr_pwdata[46:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (idx)
         rpd_pkg::REG_LEN:  csr_prdata = 64'(unsigned'(len_ff));
         rpd_pkg::REG_BETA: csr_prdata = 64'(beta_ff);
         rpd_pkg::REG_EK:   csr_prdata = 64'(ek0_ff);
         rpd_pkg::REG_MASS: csr_prdata = 64'(mass_ff);
         rpd_pkg::REG_P0:   csr_prdata = 64'(p0_ff);
         default: csr_prdata = '0;
      endcase
   end

   rpd_pkg::q_type beta, mass, p0;
   assign beta = 48'(beta_ff);
   assign mass = 48'(mass_ff);
   assign p0 = 48'(p0_ff);

   // Delay lines for the request and valid bits.
   rpd_pkg::particle_type pin, pd_ff [LAT];
   logic v_ff [LAT];
   assign pin = '{req_in_x, req_in_xp, req_in_y, req_in_yp, req_in_z, req_in_de};
   always_comb begin
      pd_ff[0] = pin;
      v_ff[0] = start;
   end
   for (genvar i = 0; i < LAT - 1; i++) begin : g_dl
      always_ff @(posedge clock) begin
         pd_ff[i+1] <= pd_ff[i];
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
      end
   end

   // Constant terms, recomputed continuously from registers.
   rpd_pkg::q_type t_q, p02;
   rpd_qdiv u_tdiv (.clock, .en(1'b1), .a(len_ff), .b(beta), .q(t_q));
   rpd_qmul u_p02 (.clock, .en(1'b1), .a(p0), .b(p0), .p(p02));

   // ek, et, et+m.
   rpd_pkg::q_type ek_ff, et_ff, etm_ff;
   rpd_pkg::q_type ek_c, et_c;
   always_comb begin
      ek_c = rpd_pkg::sat49(49'(signed'({1'b0, ek0_ff})) + 49'(req_in_de));
      et_c = rpd_pkg::sat49(49'(ek_c) + 49'(mass));
   end
   always_ff @(posedge clock) begin
      ek_ff <= ek_c;
      et_ff <= et_c;
      etm_ff <= rpd_pkg::sat49(49'(et_c) + 49'(mass));
   end
   rpd_pkg::q_type p2, p2_ff, p2d_ff;
   rpd_qmul u_p2 (.clock, .en(1'b1), .a(ek_ff), .b(etm_ff), .p(p2));
   // p2 passes through a further register (p2d_ff) so that it meets a2p of the same request.
   always_ff @(posedge clock) begin
      p2_ff <= p2;   // T_P2
      p2d_ff <= p2_ff;
   end

   // Angle products.
   rpd_pkg::q_type xpp0, ypp0, xx, yy, a2_ff, a2p, pz_ff;
   rpd_qmul u_xn (.clock, .en(1'b1), .a(req_in_xp), .b(p0), .p(xpp0));
   rpd_qmul u_yn (.clock, .en(1'b1), .a(req_in_yp), .b(p0), .p(ypp0));
   rpd_qmul u_xx (.clock, .en(1'b1), .a(req_in_xp), .b(req_in_xp), .p(xx));
   rpd_qmul u_yy (.clock, .en(1'b1), .a(req_in_yp), .b(req_in_yp), .p(yy));
   always_ff @(posedge clock) a2_ff <= rpd_pkg::sat49(49'(xx) + 49'(yy));
   rpd_qmul u_a2 (.clock, .en(1'b1), .a(a2_ff), .b(p02), .p(a2p));
   always_ff @(posedge clock) pz_ff <= rpd_pkg::sat49(49'(p2d_ff) - 49'(a2p));

   // Et delayed to the points where it divides.
   rpd_pkg::q_type et_d [T_EK:T_SQ];
   always_comb et_d[T_EK] = et_ff;
   for (genvar i = T_EK; i < T_SQ; i++) begin : g_et
      always_ff @(posedge clock) et_d[i+1] <= et_d[i];
   end
   rpd_pkg::q_type bx, by, sq, bz, bzb_ff;
   rpd_qdiv u_bx (.clock, .en(1'b1), .a(xpp0), .b(et_d[T_BXN]), .q(bx));
   rpd_qdiv u_by (.clock, .en(1'b1), .a(ypp0), .b(et_d[T_BXN]), .q(by));
   rpd_qsqrt u_sq (.clock, .en(1'b1), .v(rpd_pkg::mag(pz_ff)), .r(sq));
   rpd_qdiv u_bz (.clock, .en(1'b1), .a(sq), .b(et_d[T_SQ]), .q(bz));
   always_ff @(posedge clock) bzb_ff <= rpd_pkg::sat49(49'(bz) - 49'(beta));

   // Bring bx, by to the same time as bzb.
   localparam int BXD = T_BZ + 1 - (T_BXN + LD);
   rpd_pkg::q_type bx_d [BXD+1], by_d [BXD+1];
   always_comb begin
      bx_d[0] = bx;
      by_d[0] = by;
   end
   for (genvar i = 0; i < BXD; i++) begin : g_bx
      always_ff @(posedge clock) begin
         bx_d[i+1] <= bx_d[i];
         by_d[i+1] <= by_d[i];
      end
   end
   rpd_pkg::q_type dx, dy, dz;
   rpd_qmul u_dx (.clock, .en(1'b1), .a(bx_d[BXD]), .b(t_q), .p(dx));
   rpd_qmul u_dy (.clock, .en(1'b1), .a(by_d[BXD]), .b(t_q), .p(dy));
   rpd_qmul u_dz (.clock, .en(1'b1), .a(bzb_ff), .b(t_q), .p(dz));

   rpd_pkg::particle_type pf, out_in, out_ff;
   logic ov_ff;
   assign pf = pd_ff[LAT-1];
   always_comb begin
      out_in = pf;
      if (len_ff > 0) begin
         out_in.x = rpd_pkg::sat49(49'(pf.x) + 49'(dx));
         out_in.y = rpd_pkg::sat49(49'(pf.y) + 49'(dy));
         out_in.z = rpd_pkg::sat49(49'(pf.z) + 49'(dz));
      end
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else ov_ff <= v_ff[LAT-1];
      out_ff <= out_in;
   end
   assign rsp_valid = ov_ff;
   assign rsp_out_x = out_ff.x;
   assign rsp_out_xp = out_ff.xp;
   assign rsp_out_y = out_ff.y;
   assign rsp_out_yp = out_ff.yp;
   assign rsp_out_z = out_ff.z;
   assign rsp_out_de = out_ff.de;

   `RPD_ASSERT_NEXT(a_valid_follows, clock, reset, v_ff[LAT-1], rsp_valid, "lost result")
   `RPD_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy, "busy raised")
   `RPD_ASSERT_NEXT(a_pass, clock, reset, v_ff[LAT-1] && len_ff <= 0,
      rsp_out_xp == $past(pf.xp), "pass-through broke")
endmodule
